// File: src/phr_pkg.sv
// Package for the path history ring: sizes, codes, state and command types.
// Used by the controller, the datapath, the top level and the checker.
package phr_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = 6;
	localparam int DIR_W = 3;
	localparam int STEP_W = 8;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [DIR_W-1:0] dir_t;

	localparam dir_t DIR_MAX = 3'd5;
	localparam dir_t DIR_REV_MASK = 3'd1;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_RETRACE = 2'd1,
		OP_SHOW    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ADD_DONE = 3'd0,
		KIND_REV_STEP = 3'd1,
		KIND_RET_DONE = 3'd2,
		KIND_RUN      = 3'd3,
		KIND_EMPTY    = 3'd4
	} kind_t;

	typedef enum logic {
		RD_TAIL,
		RD_SCAN
	} rd_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_RET_STEP,
		ST_RET_EMIT,
		ST_SHOW_RD,
		ST_SHOW_CMP,
		ST_SHOW_END
	} state_t;

	typedef struct packed {
		logic    cap;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    add_exec;
		logic    clear;
		logic    pop;
		logic    scan_take;
		logic    emit;
		kind_t   kind;
		logic    last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic clear_req;
		logic walk;
		logic steps_done;
		logic scan_end;
		logic run_break;
		logic out_free;
	} dp_stat_t;

	function automatic idx_t idx_inc(idx_t i);
		idx_inc = (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction

	function automatic idx_t idx_dec(idx_t i);
		idx_dec = (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
	endfunction

	function automatic cnt_t held_of(idx_t h, idx_t t);
		logic [IDX_W:0] d;
		d = {1'b0, t} - {1'b0, h};
		if (t < h)
			d = d + (IDX_W+1)'(DEPTH);
		held_of = cnt_t'(d);
	endfunction

endpackage

// File: src/phr_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Standalone; payload widths follow the block's field list.
interface phr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [2:0] direction;
	logic [7:0] step_count;
	logic       backstep;

	modport source (output valid, op, direction, step_count, backstep, input ready);
	modport sink (input valid, op, direction, step_count, backstep, output ready);
endinterface

interface phr_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [2:0] dir_out;
	logic [5:0] count;
	logic [5:0] held;
	logic       last;

	modport source (output valid, kind, dir_out, count, held, last, input ready);
	modport sink (input valid, kind, dir_out, count, held, last, output ready);
endinterface

// File: src/phr_ctrl.sv
// Controller state machine: sequences add, retrace and show over the datapath.
// Depends on phr_pkg for states, codes and the command/status structs.
module phr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [1:0]         req_op,
	output logic               req_ready,
	input  phr_pkg::dp_stat_t  stat,
	output phr_pkg::ctrl_cmd_t cmd
);
	import phr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (op_t'(req_op))
						OP_ADD:     state_d = ST_ADD;
						OP_RETRACE: state_d = ST_RET_STEP;
						OP_SHOW:    state_d = ST_SHOW_RD;
						OP_NOP:     state_d = ST_IDLE;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				if (stat.out_free)
					state_d = ST_IDLE;
			end
			ST_RET_STEP: begin
				if (stat.clear_req && !stat.empty)
					state_d = ST_RET_STEP;
				else if (stat.empty || stat.steps_done) begin
					if (stat.out_free)
						state_d = ST_IDLE;
				end else if (stat.walk)
					state_d = ST_RET_EMIT;
			end
			ST_RET_EMIT: begin
				if (stat.out_free)
					state_d = ST_RET_STEP;
			end
			ST_SHOW_RD: begin
				if (stat.empty) begin
					if (stat.out_free)
						state_d = ST_IDLE;
				end else
					state_d = ST_SHOW_CMP;
			end
			ST_SHOW_CMP: begin
				if (!stat.run_break || stat.out_free)
					state_d = stat.scan_end ? ST_SHOW_END : ST_SHOW_RD;
			end
			ST_SHOW_END: begin
				if (stat.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		cmd = '{cap: 1'b0, rd_en: 1'b0, rd_sel: RD_TAIL, add_exec: 1'b0, clear: 1'b0,
			pop: 1'b0, scan_take: 1'b0, emit: 1'b0, kind: KIND_ADD_DONE, last: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.cap = req_valid;
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_TAIL;
			end
			ST_ADD: begin
				cmd.add_exec = stat.out_free;
				cmd.emit = stat.out_free;
				cmd.kind = KIND_ADD_DONE;
				cmd.last = 1'b1;
			end
			ST_RET_STEP: begin
				if (stat.clear_req && !stat.empty)
					cmd.clear = 1'b1;
				else if (stat.empty || stat.steps_done) begin
					cmd.emit = stat.out_free;
					cmd.kind = KIND_RET_DONE;
					cmd.last = 1'b1;
				end else begin
					cmd.pop = 1'b1;
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_TAIL;
				end
			end
			ST_RET_EMIT: begin
				cmd.emit = stat.out_free;
				cmd.kind = KIND_REV_STEP;
			end
			ST_SHOW_RD: begin
				if (stat.empty) begin
					cmd.emit = stat.out_free;
					cmd.kind = KIND_EMPTY;
					cmd.last = 1'b1;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_SCAN;
				end
			end
			ST_SHOW_CMP: begin
				cmd.scan_take = !stat.run_break || stat.out_free;
				cmd.emit = stat.run_break && stat.out_free;
				cmd.kind = KIND_RUN;
			end
			ST_SHOW_END: begin
				cmd.emit = stat.out_free;
				cmd.kind = KIND_RUN;
				cmd.last = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// File: src/phr_dp.sv
// Datapath: ring store, head/tail indexes, scan and run registers, response register.
// Depends on phr_pkg; driven by the command struct from phr_ctrl.
module phr_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic [2:0]         req_direction,
	input  logic [7:0]         req_step_count,
	input  logic               req_backstep,
	input  phr_pkg::ctrl_cmd_t cmd,
	output phr_pkg::dp_stat_t  stat,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [2:0]         rsp_kind,
	output logic [2:0]         rsp_dir_out,
	output logic [5:0]         rsp_count,
	output logic [5:0]         rsp_held,
	output logic               rsp_last
);
	import phr_pkg::*;

	dir_t              mem [DEPTH];
	logic              collapse_q;
	dir_t              dir_q;
	logic [STEP_W-1:0] steps_q;
	logic              walk_q;
	idx_t              head_q;
	idx_t              tail_q;
	idx_t              scan_q;
	cnt_t              popped_q;
	cnt_t              run_q;
	dir_t              cur_q;
	dir_t              rd_q;
	logic              out_valid_q;
	kind_t             out_kind_q;
	dir_t              out_dir_q;
	cnt_t              out_count_q;
	cnt_t              out_held_q;
	logic              out_last_q;

	idx_t tail_dec;
	idx_t tail_inc;
	idx_t head_d;
	idx_t tail_d;
	cnt_t held_now;
	logic dir_ok;
	logic add_collapse;
	idx_t rd_addr;
	dir_t emit_dir;
	cnt_t emit_count;

	assign tail_dec = idx_dec(tail_q);
	assign tail_inc = idx_inc(tail_q);
	assign held_now = held_of(head_q, tail_q);
	assign dir_ok = (dir_q <= DIR_MAX);
	assign add_collapse = collapse_q && (held_now != '0) && (dir_q == (rd_q ^ DIR_REV_MASK));
	assign rd_addr = (cmd.rd_sel == RD_TAIL) ? tail_dec : scan_q;

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		if (cmd.add_exec && dir_ok) begin
			if (add_collapse)
				tail_d = tail_dec;
			else begin
				tail_d = tail_inc;
				if (tail_inc == head_q)
					head_d = idx_inc(head_q);
			end
		end
		if (cmd.clear)
			tail_d = head_q;
		if (cmd.pop)
			tail_d = tail_dec;
	end

	always_comb begin
		emit_dir = '0;
		emit_count = '0;
		case (cmd.kind)
			KIND_REV_STEP: emit_dir = rd_q ^ DIR_REV_MASK;
			KIND_RET_DONE: emit_count = popped_q;
			KIND_RUN: begin
				emit_dir = cur_q;
				emit_count = run_q;
			end
			default: ;
		endcase
	end

	// ring store and its registered read port
	always_ff @(posedge clk) begin
		if (cmd.add_exec && dir_ok && !add_collapse)
			mem[tail_q] <= dir_q;
		if (cmd.rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collapse_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				collapse_q <= cfg_wr_data;
			head_q <= head_d;
			tail_q <= tail_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			dir_q <= req_direction;
			steps_q <= req_step_count;
			walk_q <= req_backstep;
			popped_q <= '0;
			scan_q <= head_q;
			run_q <= '0;
		end
		if (cmd.clear)
			popped_q <= held_now;
		if (cmd.pop)
			popped_q <= cnt_t'(popped_q + 1'b1);
		if (cmd.rd_en && cmd.rd_sel == RD_SCAN)
			scan_q <= idx_inc(scan_q);
		if (cmd.scan_take) begin
			if (run_q != '0 && rd_q == cur_q)
				run_q <= cnt_t'(run_q + 1'b1);
			else begin
				cur_q <= rd_q;
				run_q <= cnt_t'(1);
			end
		end
		if (cmd.emit) begin
			out_kind_q <= cmd.kind;
			out_dir_q <= emit_dir;
			out_count_q <= emit_count;
			out_held_q <= held_of(head_d, tail_d);
			out_last_q <= cmd.last;
		end
	end

	assign stat.empty = (held_now == '0);
	assign stat.clear_req = (steps_q == '0) && !walk_q;
	assign stat.walk = walk_q;
	assign stat.steps_done = (steps_q != '0) && (STEP_W'(popped_q) == steps_q);
	assign stat.scan_end = (scan_q == tail_q);
	assign stat.run_break = (run_q != '0) && (rd_q != cur_q);
	assign stat.out_free = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp_kind = out_kind_q;
	assign rsp_dir_out = out_dir_q;
	assign rsp_count = out_count_q;
	assign rsp_held = out_held_q;
	assign rsp_last = out_last_q;

endmodule

// File: src/path_history_ring_with_backtrack.sv
// Top level of the path history ring: controller plus datapath on two channels.
// Depends on phr_pkg, phr_if (phr_req_if, phr_rsp_if), phr_ctrl and phr_dp.
//
//   channel | dir | beat carries                               | notes
//   --------+-----+--------------------------------------------+-----------------------
//   req     | in  | op, direction, step_count, backstep        | one beat per operation
//   rsp     | out | kind, dir_out, count, held, last           | 1..32 beats per request
//   cfg     | in  | cfg_wr_en, cfg_wr_data (collapse_reverse)  | write only when idle
//
// Sequencing: add captures the request, then writes and emits its closing beat; retrace
// pops one step per pass through ST_RET_STEP (plus ST_RET_EMIT when each step is echoed),
// then emits the closing beat, and a clear empties the ring instead; show reads and compares
// each held entry in turn. The single read port of the ring store sets the per-entry pace.
// Reset (arst_n low) empties the ring and clears collapse_reverse; no clearing pass.
// A stalled rsp holds the controller on the pending beat; req is taken again as soon as
// the last beat of an operation sits in the response register.
module path_history_ring_with_backtrack (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	phr_req_if.sink     req,
	phr_rsp_if.source   rsp
);
	import phr_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Sequence each operation; hold req.ready low while one is in flight.
	phr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Ring store, indexes and the response register live in the datapath.
	phr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.req_direction  (req.direction),
		.req_step_count (req.step_count),
		.req_backstep   (req.backstep),
		.cmd            (cmd),
		.stat           (stat),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_kind       (rsp.kind),
		.rsp_dir_out    (rsp.dir_out),
		.rsp_count      (rsp.count),
		.rsp_held       (rsp.held),
		.rsp_last       (rsp.last)
	);

endmodule

// File: src/phr_chk.sv
// Port-level checker for the path history ring, attached by bind.
// Depends on phr_pkg for kinds and the ring depth.
module phr_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_kind,
	input logic [2:0] rsp_dir_out,
	input logic [5:0] rsp_count,
	input logic [5:0] rsp_held,
	input logic       rsp_last
);
	import phr_pkg::*;

	// a stalled beat keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_count)
			&& $stable(rsp_held) && $stable(rsp_dir_out) && $stable(rsp_last))
		else $error("rsp beat changed while stalled");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_held <= 6'(DEPTH - 1))
		else $error("held exceeds ring capacity");

	a_step_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_REV_STEP |-> !rsp_last)
		else $error("reversed step flagged last");

	a_closing_beats: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == KIND_ADD_DONE || rsp_kind == KIND_RET_DONE
			|| rsp_kind == KIND_EMPTY) |-> rsp_last)
		else $error("closing beat without last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_EMPTY |-> rsp_held == '0 && rsp_count == '0)
		else $error("empty marker with entries");

endmodule

bind path_history_ring_with_backtrack phr_chk u_phr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_kind    (rsp.kind),
	.rsp_dir_out (rsp.dir_out),
	.rsp_count   (rsp.count),
	.rsp_held    (rsp.held),
	.rsp_last    (rsp.last)
);
